// ----- hw/rtl/ppbr_pkg.sv -----
package ppbr_pkg;

   localparam int unsigned INTERVAL_BITS_DEFAULT = 16;
   localparam int unsigned TIMEOUT_WIDTH = 8;
   localparam logic [7:0] TIMEOUT_RESET = 8'd200;

   localparam logic [7:0] START_BYTE = 8'h80;
   localparam logic [7:0] LAST_BIT = 8'h01;

   typedef enum logic [1:0] {
      MODE_RX_TICK = 2'd0,
      MODE_IV_TICK = 2'd1,
      MODE_EDGE    = 2'd2
   } mode_type;

   // bit that a rising edge at reception count t sets, zero outside every window
   function automatic logic [7:0] window_bit(input logic [7:0] t);
      logic [7:0] b;
      b = 8'h00;
      if (t >= 8'd10 && t <= 8'd17) b = 8'h40;
      else if (t >= 8'd22 && t <= 8'd29) b = 8'h20;
      else if (t >= 8'd35 && t <= 8'd42) b = 8'h10;
      else if (t >= 8'd47 && t <= 8'd54) b = 8'h08;
      else if (t >= 8'd60 && t <= 8'd67) b = 8'h04;
      else if (t >= 8'd72 && t <= 8'd79) b = 8'h02;
      else if (t >= 8'd85 && t <= 8'd92) b = LAST_BIT;
      return b;
   endfunction

endpackage

// ----- hw/rtl/pulse_position_byte_receiver.sv -----
// path: an accepted transaction waits in the input register, and its result is then
//   registered in the result register; a stalled result also holds the input register
// throughput: one transaction per cycle while no result is stalled, set by the
//   combinational state update between the input register and the result register
// reset: synchronous, active high; clears all decoder state and sets
//   timeout_ff to 200
module pulse_position_byte_receiver #(
   parameter int unsigned INTERVAL_BITS = ppbr_pkg::INTERVAL_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic       req_edge_rising,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_message_valid,
   output logic [7:0] rsp_message,
   output logic [15:0] rsp_interval,
   output logic [7:0] rsp_distance,
   output logic       rsp_receiving,
   output logic       rsp_frame_error,
   output logic       rsp_timed_out,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata
);

   logic [7:0] timeout_ff;

   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_mode_ff;
   logic       s1_rising_ff;

   logic                     busy_ff, busy_in;
   logic                     falling_armed_ff, falling_armed_in;
   logic [7:0]               byte_ff, byte_in;
   logic [7:0]               rx_count_ff, rx_count_in;
   logic [INTERVAL_BITS-1:0] iv_count_ff, iv_count_in;
   logic [7:0]               distance_ff, distance_in;
   logic [7:0]               message_ff, message_in;
   logic [INTERVAL_BITS-1:0] iv_hold_ff, iv_hold_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_mv_ff, rsp_mv_in;
   logic rsp_fe_ff, rsp_fe_in;
   logic rsp_to_ff, rsp_to_in;
   logic [7:0] rsp_message_ff;
   logic [15:0] rsp_interval_ff;
   logic [7:0] rsp_distance_ff;
   logic rsp_receiving_ff;

   logic advance;
   logic [INTERVAL_BITS+15:0] iv_hold_ext;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign s1_valid_in = (req_valid && !req_stall) || (s1_valid_ff && !advance);
   assign rsp_valid_in = (s1_valid_ff && advance) || (rsp_valid_ff && rsp_stall);
   assign csr_ready = 1'b1;
   assign iv_hold_ext = {16'd0, iv_hold_in};

   always_comb begin
      logic [7:0] rx_inc;
      logic [7:0] wbit;
      busy_in = busy_ff;
      falling_armed_in = falling_armed_ff;
      byte_in = byte_ff;
      rx_count_in = rx_count_ff;
      iv_count_in = iv_count_ff;
      distance_in = distance_ff;
      message_in = message_ff;
      iv_hold_in = iv_hold_ff;
      rsp_mv_in = 1'b0;
      rsp_fe_in = 1'b0;
      rsp_to_in = 1'b0;
      rx_inc = rx_count_ff + 8'd1;
      wbit = ppbr_pkg::window_bit(rx_count_ff);
      unique case (s1_mode_ff)
         ppbr_pkg::MODE_RX_TICK: begin
            rx_count_in = rx_inc;
            if (rx_inc == timeout_ff) begin
               rx_count_in = 8'd0;
               busy_in = 1'b0;
               byte_in = 8'd0;
               rsp_to_in = 1'b1;
            end
         end
         ppbr_pkg::MODE_IV_TICK: begin
            iv_count_in = iv_count_ff + INTERVAL_BITS'(1);
         end
         ppbr_pkg::MODE_EDGE: begin
            if (s1_rising_ff != falling_armed_ff) begin
               if (!busy_ff) begin
                  // frame start
                  rx_count_in = 8'd0;
                  busy_in = 1'b1;
                  byte_in = ppbr_pkg::START_BYTE;
                  falling_armed_in = 1'b1;
               end else if (falling_armed_ff) begin
                  distance_in = rx_count_ff;
                  falling_armed_in = 1'b0;
               end else if (wbit == 8'd0) begin
                  busy_in = 1'b0;
                  rx_count_in = 8'd0;
                  byte_in = 8'd0;
                  rsp_fe_in = 1'b1;
               end else if (wbit == ppbr_pkg::LAST_BIT) begin
                  message_in = byte_ff | ppbr_pkg::LAST_BIT;
                  iv_hold_in = iv_count_ff;
                  iv_count_in = '0;
                  busy_in = 1'b0;
                  rx_count_in = 8'd0;
                  byte_in = 8'd0;
                  rsp_mv_in = 1'b1;
               end else begin
                  byte_in = byte_ff | wbit;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ppbr_pkg::TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_mode_ff <= req_mode;
         s1_rising_ff <= req_edge_rising;
      end
   end

   // decoder state moves only when the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         falling_armed_ff <= 1'b0;
         byte_ff <= 8'd0;
         rx_count_ff <= 8'd0;
         iv_count_ff <= '0;
         distance_ff <= 8'd0;
         message_ff <= 8'd0;
         iv_hold_ff <= '0;
      end else if (s1_valid_ff && advance) begin
         busy_ff <= busy_in;
         falling_armed_ff <= falling_armed_in;
         byte_ff <= byte_in;
         rx_count_ff <= rx_count_in;
         iv_count_ff <= iv_count_in;
         distance_ff <= distance_in;
         message_ff <= message_in;
         iv_hold_ff <= iv_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         rsp_mv_ff <= rsp_mv_in;
         rsp_fe_ff <= rsp_fe_in;
         rsp_to_ff <= rsp_to_in;
         rsp_message_ff <= message_in;
         rsp_interval_ff <= iv_hold_ext[15:0];
         rsp_distance_ff <= distance_in;
         rsp_receiving_ff <= busy_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_message_valid = rsp_mv_ff;
   assign rsp_message = rsp_message_ff;
   assign rsp_interval = rsp_interval_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_receiving = rsp_receiving_ff;
   assign rsp_frame_error = rsp_fe_ff;
   assign rsp_timed_out = rsp_to_ff;

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_mv_ff, rsp_fe_ff, rsp_to_ff}))
      else $error("more than one event pulse in a transaction");

   a_end_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_mv_ff || rsp_fe_ff || rsp_to_ff) |-> !rsp_receiving_ff)
      else $error("frame end left receiving set");

   a_busy_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_receiving_ff == busy_ff)
      else $error("pending result disagrees with decoder state");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_mv_ff || rsp_fe_ff) |-> rx_count_ff == 8'd0 && byte_ff == 8'd0)
      else $error("frame end did not clear the counter and byte");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(busy_ff) && $stable(rx_count_ff))
      else $error("decoder state moved while the result was held");

endmodule
